>>> rtl/simhash_fingerprint_accumulator_macros.svh
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator assertion macros
// Concurrent check wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SIMHASH_FINGERPRINT_ACCUMULATOR_MACROS_SVH
`define SIMHASH_FINGERPRINT_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SFA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed")
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed")
`else
`define SFA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sfa_pkg.sv
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator package
// Shared widths, parameter defaults and the controller command type.
// ---------------------------------------------------------------------------
package sfa_pkg;

	localparam int HASH_W          = 63;
	localparam int FP_W            = 63;
	localparam int USED_BITS_DEF   = 63;
	localparam int VOTE_WIDTH_DEF  = 16;

	typedef struct packed {
		logic vote;
		logic emit;
	} sfa_cmd_t;

endpackage

>>> rtl/simhash_fingerprint_accumulator.sv
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator
// Votes token hash bits per document and emits the document fingerprint.
// ---------------------------------------------------------------------------
// Input: one token hash per request on hash_word, with last_of_document
// marking the final hash of a document. A request is taken at a clock edge
// with in_valid high and in_stall low.
// Output: one fingerprint request per document, on the cycle after the last
// hash is taken; it holds in the output register while out_stall is high.
// Throughput: one hash per cycle while in_stall is low; all bit counters
// update in parallel. in_stall rises only while a fingerprint waits and
// out_stall is high; otherwise the next document streams in while the last
// result is read.
// Reset: arst_n clears every vote counter and marks the output register empty.
// Counters saturate at plus or minus 2^(VOTE_WIDTH-1)-1 and clear after
// each document.
// ---------------------------------------------------------------------------
`include "simhash_fingerprint_accumulator_macros.svh"

module simhash_fingerprint_accumulator
	import sfa_pkg::*;
#(
	parameter int USED_BITS  = USED_BITS_DEF,
	parameter int VOTE_WIDTH = VOTE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [HASH_W-1:0] hash_word,
	input  logic              last_of_document,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [FP_W-1:0]   fingerprint
);

	sfa_cmd_t cmd;

	sfa_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.last_of_document (last_of_document),
		.in_stall         (in_stall),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.cmd              (cmd)
	);

	sfa_datapath #(
		.USED_BITS  (USED_BITS),
		.VOTE_WIDTH (VOTE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.hash_word   (hash_word),
		.fingerprint (fingerprint)
	);

	`SFA_ASSERT_NEXT(a_last_emits, clk, arst_n,
		in_valid && !in_stall && last_of_document, out_valid);
	`SFA_ASSERT_SAME(a_full_stall_blocks, clk, arst_n,
		out_valid && out_stall, in_stall);
	`SFA_ASSERT_NEXT(a_taken_drains, clk, arst_n,
		out_valid && !out_stall && !(in_valid && last_of_document), !out_valid);

endmodule

>>> rtl/sfa_ctrl.sv
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator controller
// Tracks the output register and issues vote and emit commands.
// ---------------------------------------------------------------------------
module sfa_ctrl
	import sfa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     last_of_document,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output sfa_cmd_t cmd
);

	localparam logic ST_EMPTY = 1'b0;
	localparam logic ST_FULL  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;
	logic taken;

	assign in_stall  = (state_q == ST_FULL) && out_stall;
	assign accept    = in_valid && !in_stall;
	assign taken     = (state_q == ST_FULL) && !out_stall;
	assign out_valid = (state_q == ST_FULL);

	assign cmd.vote = accept;
	assign cmd.emit = accept && last_of_document;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_EMPTY: begin
				if (cmd.emit) begin
					state_d = ST_FULL;
				end
			end
			ST_FULL: begin
				if (cmd.emit) begin
					state_d = ST_FULL;
				end else if (taken) begin
					state_d = ST_EMPTY;
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/sfa_datapath.sv
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator datapath
// One saturating vote counter per used bit and the fingerprint register.
// ---------------------------------------------------------------------------
module sfa_datapath
	import sfa_pkg::*;
#(
	parameter int USED_BITS  = USED_BITS_DEF,
	parameter int VOTE_WIDTH = VOTE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sfa_cmd_t          cmd,
	input  logic [HASH_W-1:0] hash_word,
	output logic [FP_W-1:0]   fingerprint
);

	localparam logic signed [VOTE_WIDTH-1:0] VOTE_MAX = {1'b0, {(VOTE_WIDTH-1){1'b1}}};
	localparam logic signed [VOTE_WIDTH-1:0] VOTE_MIN = -VOTE_MAX;
	localparam logic signed [VOTE_WIDTH-1:0] VOTE_ONE = {{(VOTE_WIDTH-1){1'b0}}, 1'b1};

	logic [63:0]          word_ext;
	logic [USED_BITS-1:0] pos;
	logic [63:0]          fp_ext;
	logic [FP_W-1:0]      fingerprint_q;

	assign word_ext = {{(64-HASH_W){1'b0}}, hash_word};

	for (genvar i = 0; i < USED_BITS; i++) begin : g_lane
		logic signed [VOTE_WIDTH-1:0] cnt_q;
		logic signed [VOTE_WIDTH-1:0] cnt_d;

		always_comb begin
			cnt_d = cnt_q;
			if (word_ext[i]) begin
				if (cnt_q != VOTE_MAX) begin
					cnt_d = cnt_q + VOTE_ONE;
				end
			end else begin
				if (cnt_q != VOTE_MIN) begin
					cnt_d = cnt_q - VOTE_ONE;
				end
			end
		end

		assign pos[i] = !cnt_d[VOTE_WIDTH-1] && (cnt_d != '0);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cnt_q <= '0;
			end else if (cmd.emit) begin
				cnt_q <= '0;
			end else if (cmd.vote) begin
				cnt_q <= cnt_d;
			end
		end
	end

	assign fp_ext = 64'(pos);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fingerprint_q <= fp_ext[FP_W-1:0];
		end
	end

	assign fingerprint = fingerprint_q;

endmodule

>>> test/tb_simhash_fingerprint_accumulator.sv
// ---------------------------------------------------------------------------
// Simhash fingerprint accumulator testbench
// Streams token hashes grouped into documents and checks every emitted
// fingerprint against a bit-vote predictor with saturating counters, under
// random idling on both sides and a long output hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_simhash_fingerprint_accumulator
	import sfa_pkg::*;
();

	localparam int VOTE_LIMIT   = (1 << (VOTE_WIDTH_DEF - 1)) - 1;
	localparam int STALL_LIMIT  = 20000;
	localparam int DRAIN_CYCLES = 20;

	class fingerprint_scoreboard;
		int                vote_count [USED_BITS_DEF];
		logic [FP_W-1:0]   fingerprint_due [$];
		int                failures;

		function new();
			failures = 0;
			foreach (vote_count[i])
				vote_count[i] = 0;
		endfunction

		function void note_hash(logic [HASH_W-1:0] word, logic is_last);
			logic [FP_W-1:0] fp;
			fp = '0;
			for (int i = 0; i < USED_BITS_DEF; i++) begin
				if (word[i])
					vote_count[i] = vote_count[i] + 1;
				else
					vote_count[i] = vote_count[i] - 1;
				if (vote_count[i] > VOTE_LIMIT)
					vote_count[i] = VOTE_LIMIT;
				if (vote_count[i] < -VOTE_LIMIT)
					vote_count[i] = -VOTE_LIMIT;
			end
			if (is_last) begin
				for (int i = 0; i < USED_BITS_DEF; i++) begin
					fp[i] = (vote_count[i] > 0);
					vote_count[i] = 0;
				end
				fingerprint_due.push_back(fp);
			end
		endfunction

		function void check_fingerprint(logic [FP_W-1:0] fp);
			logic [FP_W-1:0] want;
			if (fingerprint_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("fingerprint with none due: %h", fp);
			end else begin
				want = fingerprint_due.pop_front();
				if (fp !== want) begin
					failures++;
					if (failures <= 10)
						$display("fingerprint mismatch: expected %h, got %h", want, fp);
				end
			end
		endfunction

		function int pending();
			return fingerprint_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [HASH_W-1:0] hash_word;
	logic              last_of_document;
	logic              out_valid;
	logic              out_stall;
	logic [FP_W-1:0]   fingerprint;

	fingerprint_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int hashes_sent;

	simhash_fingerprint_accumulator u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.hash_word        (hash_word),
		.last_of_document (last_of_document),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.fingerprint      (fingerprint)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [HASH_W-1:0] random_hash();
		logic [63:0] a, b, c;
		a = {$urandom, $urandom};
		b = {$urandom, $urandom};
		c = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: return '1;
			1: return '0;
			2: return HASH_W'(1) << $urandom_range(0, HASH_W - 1);
			3: return HASH_W'(a & b & c);
			4: return HASH_W'(a | b | c);
			default: return HASH_W'(a);
		endcase
	endfunction

	task automatic send_hash(input logic [HASH_W-1:0] word, input logic is_last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		hash_word <= word;
		last_of_document <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_hash(word, is_last);
		hashes_sent++;
	endtask

	task automatic send_random_document(input int max_len);
		int len;
		int pick;
		logic [HASH_W-1:0] base;
		logic related;
		pick = $urandom_range(0, 99);
		if (pick < 80)
			len = $urandom_range(1, 8);
		else if (pick < 98)
			len = $urandom_range(9, 64);
		else
			len = $urandom_range(65, 400);
		if (len > max_len)
			len = max_len;
		base = random_hash();
		related = ($urandom_range(0, 99) < 40);
		for (int i = 0; i < len; i++) begin
			if (related)
				send_hash(base ^ (random_hash() & random_hash() & random_hash()),
					i == len - 1);
			else
				send_hash(random_hash(), i == len - 1);
		end
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic random_phase(input int hashes);
		int target;
		target = hashes_sent + hashes;
		while (hashes_sent < target)
			send_random_document(64);
	endtask

	// receive side: check accepted fingerprints, then decide next stall
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_fingerprint(fingerprint);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_simhash_fingerprint_accumulator failed");
		$finish;
	end

	initial begin
		logic [HASH_W-1:0] word_a;
		board = new();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		hashes_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		hash_word <= '0;
		last_of_document <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, ties, single-bit words, short majority documents
		send_hash('1, 1'b1);
		send_hash('0, 1'b1);
		send_hash(HASH_W'(1), 1'b1);
		send_hash(HASH_W'(1) << (HASH_W - 1), 1'b1);
		word_a = random_hash();
		send_hash(word_a, 1'b0);
		send_hash(~word_a, 1'b1);
		send_hash(word_a, 1'b0);
		send_hash(word_a, 1'b0);
		send_hash(~word_a, 1'b1);
		send_hash('1, 1'b0);
		send_hash('0, 1'b0);
		send_hash('1, 1'b0);
		send_hash('0, 1'b1);
		send_hash(HASH_W'({$urandom, $urandom}), 1'b0);
		send_hash(HASH_W'({$urandom, $urandom}), 1'b0);
		send_hash(HASH_W'({$urandom, $urandom}), 1'b1);
		wait_drain();

		// sender idles lightly, receiver heavily
		send_idle_pct = 10;
		recv_idle_pct = 71;
		random_phase(200);

		// long output hold-off while short documents keep coming
		hold_left = 300;
		for (int i = 0; i < 40; i++)
			send_random_document(2);
		wait_drain();

		send_idle_pct = 71;
		recv_idle_pct = 10;
		random_phase(250);
		wait_drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(250);

		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0)
			$display("tb_simhash_fingerprint_accumulator passed");
		else
			$display("tb_simhash_fingerprint_accumulator failed");
		$finish;
	end

endmodule
